// File: rtl/pnguf_pkg.sv
// Shared types and constants for the PNG scanline unfilter and composite block.
package pnguf_pkg;

    // Row store sizing
    localparam int MAX_COLUMNS  = 4096;
    localparam int MAX_CHANNELS = 4;
    localparam int ROW_BYTES    = MAX_COLUMNS * MAX_CHANNELS;
    localparam int IDX_W        = $clog2(ROW_BYTES);
    localparam int BIR_W        = $clog2(ROW_BYTES + 1);
    localparam int COL_W        = $clog2(MAX_COLUMNS + 1);

    // Register field widths
    localparam int WIDTH_W      = 13;
    localparam int HEIGHT_W     = 14;
    localparam int CFG_DATA_W   = 14;
    localparam int CFG_INDEX_W  = 2;

    // Byte position modulo the lcm of all channel counts
    localparam int PHASE_MOD    = 12;
    localparam int PHASE_W      = $clog2(PHASE_MOD);

    // Front to back queue
    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] MAX_FILTER   = 8'd4;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_COLOR_KIND   = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        COLOR_GRAY       = 2'd0,
        COLOR_RGB        = 2'd1,
        COLOR_GRAY_ALPHA = 2'd2,
        COLOR_RGBA       = 2'd3
    } color_kind_t;

    typedef enum logic [2:0] {
        FILT_NONE    = 3'd0,
        FILT_SUB     = 3'd1,
        FILT_UP      = 3'd2,
        FILT_AVERAGE = 3'd3,
        FILT_PAETH   = 3'd4
    } filter_t;

    typedef enum logic {
        KIND_DATA  = 1'b0,
        KIND_ERROR = 1'b1
    } item_kind_t;

    // Where the above byte of an item in flight comes from
    typedef enum logic [1:0] {
        FWD_RAM  = 2'd0,
        FWD_HELD = 2'd1,
        FWD_LAST = 2'd2
    } fwd_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       image_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
        logic       bad_filter;
    } out_item_t;

    // Classified work handed from front to back
    typedef struct packed {
        item_kind_t       kind;
        logic [7:0]       data_byte;
        filter_t          row_filter;
        logic [IDX_W-1:0] idx;
        logic             row_zero;
        logic             row_first;
        logic             pixel_end;
        logic             last_pixel;
    } q_item_t;

    typedef struct packed {
        logic    valid;
        q_item_t item;
    } q_push_t;

    // Pixel ready for compositing
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last_pixel;
        logic       bad_filter;
    } pix_stage_t;

endpackage

// File: rtl/pnguf_ram.sv
// Generic single write port, single read port RAM with registered read data.
module pnguf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/pnguf_front.sv
// Front end: configuration registers, row/byte tracking and classification of each byte.
module pnguf_front
    import pnguf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  in_item_t               byte_data,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output color_kind_t            color_kind,
    output q_push_t                push,
    input  logic                   q_full
);

    logic [WIDTH_W-1:0]  width_reg, width_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    color_kind_t         color_reg, color_next;
    logic [BIR_W-1:0]    bir_reg, bir_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    filter_t             filter_reg, filter_next;
    logic                err_reg, err_next;

    logic [COL_W-1:0]    cols;
    logic [BIR_W-1:0]    stride;
    logic [HEIGHT_W-1:0] rows;
    logic                acc;
    logic                err_s;
    logic [BIR_W-1:0]    bir_s, bir_e, bir_inc, idx_full;
    logic [PHASE_W-1:0]  ph_s, ph_e;
    logic [HEIGHT_W-1:0] row_s, row_e, row_inc;
    logic                is_filter, bad, row_end, pixel_end, last;

    // Configuration writes
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        color_next  = color_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_next  = cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_next = cfg_data[HEIGHT_W-1:0];
                REG_COLOR_KIND:   color_next  = color_kind_t'(cfg_data[1:0]);
                default:          ;
            endcase
        end
    end

    // Effective geometry
    always_comb
    begin
        if (width_reg == '0)
            cols = COL_W'(1);
        else if (int'(width_reg) > MAX_COLUMNS)
            cols = COL_W'(MAX_COLUMNS);
        else
            cols = COL_W'(width_reg);

        case (color_reg)
            COLOR_GRAY:       stride = BIR_W'(cols);
            COLOR_RGB:        stride = BIR_W'(cols) + (BIR_W'(cols) << 1);
            COLOR_GRAY_ALPHA: stride = BIR_W'(cols) << 1;
            COLOR_RGBA:       stride = BIR_W'(cols) << 2;
        endcase

        rows = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
    end

    assign byte_stall = q_full;
    assign acc        = byte_valid && !byte_stall;
    assign color_kind = color_reg;

    // Position of this byte after image start and register changes
    always_comb
    begin
        err_s = byte_data.image_start ? 1'b0 : err_reg;
        bir_s = byte_data.image_start ? '0 : bir_reg;
        ph_s  = byte_data.image_start ? '0 : phase_reg;
        row_s = byte_data.image_start ? '0 : row_reg;

        row_e = (row_s >= rows) ? '0 : row_s;
        bir_e = (bir_s > stride) ? '0 : bir_s;
        ph_e  = (bir_s > stride) ? '0 : ph_s;

        is_filter = (bir_e == '0);
        bad       = byte_data.data_byte > MAX_FILTER;
        bir_inc   = bir_e + BIR_W'(1);
        row_end   = bir_inc > stride;
        row_inc   = row_e + HEIGHT_W'(1);
        idx_full  = bir_e - BIR_W'(1);

        case (color_reg)
            COLOR_GRAY:       pixel_end = 1'b1;
            COLOR_GRAY_ALPHA: pixel_end = (ph_e[0] == 1'b0);
            COLOR_RGBA:       pixel_end = (ph_e[1:0] == 2'b00);
            COLOR_RGB:        pixel_end = (ph_e == PHASE_W'(0)) || (ph_e == PHASE_W'(3)) ||
                                          (ph_e == PHASE_W'(6)) || (ph_e == PHASE_W'(9));
        endcase

        last = (row_e == rows - HEIGHT_W'(1)) && (bir_e == stride);
    end

    // Row state update
    always_comb
    begin
        bir_next    = bir_reg;
        phase_next  = phase_reg;
        row_next    = row_reg;
        filter_next = filter_reg;
        err_next    = err_reg;
        if (acc && !err_s)
        begin
            err_next   = 1'b0;
            row_next   = row_e;
            bir_next   = bir_e;
            phase_next = ph_e;
            if (is_filter)
            begin
                if (bad)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    filter_next = filter_t'(byte_data.data_byte[2:0]);
                    bir_next    = BIR_W'(1);
                    phase_next  = PHASE_W'(1);
                end
            end
            else if (row_end)
            begin
                bir_next   = '0;
                phase_next = '0;
                row_next   = (row_inc >= rows) ? '0 : row_inc;
            end
            else
            begin
                bir_next   = bir_inc;
                phase_next = (ph_e == PHASE_W'(PHASE_MOD - 1)) ? '0 : ph_e + PHASE_W'(1);
            end
        end
    end

    // Transaction into the queue: data bytes and bad filter bytes
    always_comb
    begin
        push.valid          = acc && !err_s && (!is_filter || bad);
        push.item.kind      = is_filter ? KIND_ERROR : KIND_DATA;
        push.item.data_byte = byte_data.data_byte;
        push.item.row_filter = filter_reg;
        push.item.idx       = idx_full[IDX_W-1:0];
        push.item.row_zero  = (row_e == '0);
        push.item.row_first = (bir_e == BIR_W'(1));
        push.item.pixel_end = pixel_end;
        push.item.last_pixel = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_W'(1);
            height_reg <= HEIGHT_W'(1);
            color_reg  <= COLOR_GRAY;
            bir_reg    <= '0;
            phase_reg  <= '0;
            row_reg    <= '0;
            filter_reg <= FILT_NONE;
            err_reg    <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            color_reg  <= color_next;
            bir_reg    <= bir_next;
            phase_reg  <= phase_next;
            row_reg    <= row_next;
            filter_reg <= filter_next;
            err_reg    <= err_next;
        end
    end

    // A bad filter byte locks out the stream until the next image start
    a_err_locks: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid && push.item.kind == KIND_ERROR |=> err_reg)
        else $error("error item sent without setting the error flag");

endmodule

// File: rtl/pnguf_queue.sv
// Short FIFO between the front end and the reconstruction back end.
module pnguf_queue
    import pnguf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_push_t push,
    output logic    full,
    input  logic    pop,
    output logic    head_valid,
    output q_item_t head
);

    q_item_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 do_push, do_pop;

    assign full       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + Q_PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + Q_PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + Q_CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue occupancy beyond depth");

endmodule

// File: rtl/pnguf_back.sv
// Back end: row store, filter reconstruction, pixel assembly and compositing onto white.
module pnguf_back
    import pnguf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  color_kind_t color_kind,
    input  logic        head_valid,
    input  q_item_t     head,
    output logic        pop,
    output logic        pixel_valid,
    input  logic        pixel_stall,
    output out_item_t   pixel_data
);

    // Byte one pixel back in a shift word of reconstructed bytes
    function automatic logic [7:0] pixel_back(input logic [31:0] word, input color_kind_t kind);
        logic [7:0] res;
        case (kind)
            COLOR_GRAY:       res = word[7:0];
            COLOR_GRAY_ALPHA: res = word[15:8];
            COLOR_RGB:        res = word[23:16];
            COLOR_RGBA:       res = word[31:24];
        endcase
        return res;
    endfunction

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [10:0] sa, sb, sc, p, da, db, dc;
        sa = $signed({3'b000, a});
        sb = $signed({3'b000, b});
        sc = $signed({3'b000, c});
        p  = sa + sb - sc;
        da = (p - sa < 0) ? sa - p : p - sa;
        db = (p - sb < 0) ? sb - p : p - sb;
        dc = (p - sc < 0) ? sc - p : p - sc;
        if (da <= db && da <= dc)
            return a;
        else if (db <= dc)
            return b;
        else
            return c;
    endfunction

    // (v*a + 255*(255-a) + 127) / 255, division by 255 via shift-and-add
    function automatic logic [7:0] blend_white(input logic [7:0] v, input logic [7:0] a);
        logic [16:0] inv, x, q;
        inv = 17'(ALPHA_OPAQUE - a);
        x   = 17'(v) * 17'(a) + ((inv << 8) - inv) + 17'(127);
        q   = (x + 17'(1) + (x >> 8)) >> 8;
        return q[7:0];
    endfunction

    logic       adv;

    // Stage 1: waiting on the row store read
    logic       b1_valid_reg;
    q_item_t    b1_item_reg;
    fwd_t       b1_fwd_reg;
    logic [7:0] b1_held_reg;
    fwd_t       fwd_sel;

    // Stage 2: reconstruction
    logic       b2_valid_reg;
    q_item_t    b2_item_reg;
    logic [7:0] b2_above_reg;
    logic       b2_use_last_reg;

    logic [31:0] left_reg, left_next;
    logic [31:0] diag_reg, diag_next;
    logic [7:0]  last_recon_reg;

    logic [7:0]  above, left, diag, pred, recon;
    logic [8:0]  avg_sum;
    logic [31:0] left_base, diag_base;
    logic        b2_write;

    // Stage 3: compositing inputs
    logic        b3_valid_reg;
    pix_stage_t  b3_reg, b3_next;

    // Output register
    logic        out_valid_reg;
    out_item_t   out_reg, out_next;

    logic [7:0]  ram_rd_data;

    assign adv = !out_valid_reg || !pixel_stall;
    assign pop = head_valid && adv;

    // Above byte source for the item entering stage 1
    always_comb
    begin
        if (b1_valid_reg && b1_item_reg.kind == KIND_DATA && b1_item_reg.idx == head.idx)
            fwd_sel = FWD_LAST;
        else if (b2_valid_reg && b2_item_reg.kind == KIND_DATA && b2_item_reg.idx == head.idx)
            fwd_sel = FWD_HELD;
        else
            fwd_sel = FWD_RAM;
    end

    pnguf_ram #(
        .WIDTH (8),
        .DEPTH (ROW_BYTES)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (b2_write),
        .wr_addr (b2_item_reg.idx),
        .wr_data (recon),
        .rd_en   (pop),
        .rd_addr (head.idx),
        .rd_data (ram_rd_data)
    );

    // Filter reconstruction
    always_comb
    begin
        left_base = b2_item_reg.row_first ? '0 : left_reg;
        diag_base = b2_item_reg.row_first ? '0 : diag_reg;
        above     = b2_item_reg.row_zero ? 8'd0 :
                    (b2_use_last_reg ? last_recon_reg : b2_above_reg);
        left      = pixel_back(left_base, color_kind);
        diag      = b2_item_reg.row_zero ? 8'd0 : pixel_back(diag_base, color_kind);
        avg_sum   = 9'(left) + 9'(above);

        case (b2_item_reg.row_filter)
            FILT_SUB:     pred = left;
            FILT_UP:      pred = above;
            FILT_AVERAGE: pred = avg_sum[8:1];
            FILT_PAETH:   pred = paeth_pick(left, above, diag);
            default:      pred = 8'd0;
        endcase

        recon     = b2_item_reg.data_byte + pred;
        left_next = {left_base[23:0], recon};
        diag_next = {diag_base[23:0], above};
        b2_write  = adv && b2_valid_reg && b2_item_reg.kind == KIND_DATA;
    end

    // Pixel assembly from the newest bytes
    always_comb
    begin
        b3_next.alpha      = ALPHA_OPAQUE;
        b3_next.last_pixel = b2_item_reg.last_pixel;
        b3_next.bad_filter = 1'b0;
        case (color_kind)
            COLOR_GRAY:
            begin
                b3_next.red   = left_next[7:0];
                b3_next.green = left_next[7:0];
                b3_next.blue  = left_next[7:0];
            end
            COLOR_GRAY_ALPHA:
            begin
                b3_next.red   = left_next[15:8];
                b3_next.green = left_next[15:8];
                b3_next.blue  = left_next[15:8];
                b3_next.alpha = left_next[7:0];
            end
            COLOR_RGB:
            begin
                b3_next.red   = left_next[23:16];
                b3_next.green = left_next[15:8];
                b3_next.blue  = left_next[7:0];
            end
            COLOR_RGBA:
            begin
                b3_next.red   = left_next[31:24];
                b3_next.green = left_next[23:16];
                b3_next.blue  = left_next[15:8];
                b3_next.alpha = left_next[7:0];
            end
        endcase
        if (b2_item_reg.kind == KIND_ERROR)
        begin
            b3_next.red        = 8'd0;
            b3_next.green      = 8'd0;
            b3_next.blue       = 8'd0;
            b3_next.alpha      = ALPHA_OPAQUE;
            b3_next.last_pixel = 1'b0;
            b3_next.bad_filter = 1'b1;
        end
    end

    // Compositing onto white
    always_comb
    begin
        out_next.red        = blend_white(b3_reg.red, b3_reg.alpha);
        out_next.green      = blend_white(b3_reg.green, b3_reg.alpha);
        out_next.blue       = blend_white(b3_reg.blue, b3_reg.alpha);
        out_next.last_pixel = b3_reg.last_pixel;
        out_next.bad_filter = b3_reg.bad_filter;
    end

    // Stage valids and row context
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg   <= 1'b0;
            b2_valid_reg   <= 1'b0;
            b3_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            left_reg       <= '0;
            diag_reg       <= '0;
            last_recon_reg <= '0;
        end
        else if (adv)
        begin
            b1_valid_reg  <= pop;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg &&
                             (b2_item_reg.kind == KIND_ERROR || b2_item_reg.pixel_end);
            out_valid_reg <= b3_valid_reg;
            if (b2_write)
            begin
                left_reg       <= left_next;
                diag_reg       <= diag_next;
                last_recon_reg <= recon;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_item_reg     <= head;
            b1_fwd_reg      <= fwd_sel;
            b1_held_reg     <= recon;
            b2_item_reg     <= b1_item_reg;
            b2_above_reg    <= (b1_fwd_reg == FWD_HELD) ? b1_held_reg : ram_rd_data;
            b2_use_last_reg <= (b1_fwd_reg == FWD_LAST);
            b3_reg          <= b3_next;
            out_reg         <= out_next;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel_data  = out_reg;

    // Forwarding from the previous item needs that item directly ahead in stage 2
    a_fwd_last_pair: assert property (@(posedge clk) disable iff (!rst_n)
        b1_valid_reg && b1_fwd_reg == FWD_LAST |-> b2_valid_reg && b2_item_reg.kind == KIND_DATA)
        else $error("forward from previous item without a data item in stage 2");

    // First byte of a row starts from cleared left context
    a_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
        b2_write && b2_item_reg.row_first |=> left_reg[31:8] == '0)
        else $error("left context not cleared at row start");

    a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.bad_filter |-> out_reg.red == 8'd0 && out_reg.green == 8'd0 &&
        out_reg.blue == 8'd0 && !out_reg.last_pixel)
        else $error("error result carries color or end of image");

endmodule

// File: rtl/png_unfilter_rgb_composite.sv
// Top level of the PNG scanline unfilter with compositing of RGB output onto white.
//
// Input channel byte_valid/byte_stall/byte_data carries the inflated scanline stream, one
// byte per transaction, filter bytes included; image_start marks the first byte of an image.
// Output channel pixel_valid/pixel_stall/pixel_data carries one composited RGB pixel when the
// last byte of a pixel is reconstructed, or one error transaction for a filter byte above 4.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data), written while idle.
//
// Throughput is one byte per cycle while the queue is not full and pixel_stall does not
// hold the back end. The left-neighbor add loop closes in a single reconstruction stage,
// and the row store takes one read and one write each cycle. From the accepted last byte
// of a pixel to pixel_valid the byte passes the queue, the row store read, reconstruction,
// the stage 3 register and compositing into the output register.
// Reset clears row position, error and configuration (width 1, height 1, gray); the row
// store is not cleared, since the first row of each image ignores what it reads.
// When pixel_stall is high with a pixel in the output register, the whole back end holds;
// the 4-entry queue keeps taking bytes until it fills, and then byte_stall rises.
module png_unfilter_rgb_composite
    import pnguf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  in_item_t               byte_data,
    output logic                   pixel_valid,
    input  logic                   pixel_stall,
    output out_item_t              pixel_data,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    color_kind_t color_kind;
    q_push_t     push;
    logic        q_full;
    logic        q_pop;
    logic        head_valid;
    q_item_t     head;

    pnguf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .color_kind (color_kind),
        .push       (push),
        .q_full     (q_full)
    );

    pnguf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head       (head)
    );

    pnguf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .color_kind  (color_kind),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (q_pop),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_data  (pixel_data)
    );

endmodule

// File: tb/png_unfilter_rgb_composite_tb.sv
// Self-checking testbench for the PNG scanline unfilter and white-background compositor.
module png_unfilter_rgb_composite_tb;
    import pnguf_pkg::*;

    localparam int GAP_MAX        = 14;
    localparam int HOLD_CYCLES    = 200;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_BYTES   = 330;
    localparam int MAX_ROWS_SENT  = 4;

    logic                   clk;
    logic                   rst_n;
    logic                   byte_valid;
    logic                   byte_stall;
    in_item_t               byte_data;
    logic                   pixel_valid;
    logic                   pixel_stall;
    out_item_t              pixel_data;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Shadow copy of the register file
    logic [WIDTH_W-1:0]  shadow_width;
    logic [HEIGHT_W-1:0] shadow_height;
    color_kind_t         shadow_color;

    // Shadow copy of the unfilter state
    logic [7:0]  above_row [ROW_BYTES];
    bit          row_written [ROW_BYTES];
    logic [31:0] recon_hist;
    logic [31:0] above_hist;
    int unsigned col_byte;
    int unsigned cur_row;
    filter_t     cur_filter;
    bit          in_error;

    out_item_t   pending_pixels [$];
    int unsigned mismatches;
    int unsigned bytes_taken;
    int unsigned idle_count;
    int unsigned send_gap_max;
    int unsigned recv_stall_max;
    bit          hold_request;

    png_unfilter_rgb_composite dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_data   (byte_data),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_data  (pixel_data),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------
    // Unfilter and composite predictor
    // ---------------------------------------------------------------
    function automatic int unsigned channels_of(color_kind_t kind);
        case (kind)
            COLOR_GRAY:       return 1;
            COLOR_RGB:        return 3;
            COLOR_GRAY_ALPHA: return 2;
            default:          return 4;
        endcase
    endfunction

    function automatic int unsigned image_rows();
        return (shadow_height == 0) ? 1 : shadow_height;
    endfunction

    function automatic int unsigned row_stride();
        int unsigned cols;
        cols = (shadow_width == 0) ? 1 : shadow_width;
        if (cols > MAX_COLUMNS)
            cols = MAX_COLUMNS;
        return cols * channels_of(shadow_color);
    endfunction

    function automatic int unsigned paeth_pick(int a, int b, int c);
        int p;
        int da;
        int db;
        int dc;
        p  = a + b - c;
        da = (p > a) ? p - a : a - p;
        db = (p > b) ? p - b : b - p;
        dc = (p > c) ? p - c : c - p;
        if (da <= db && da <= dc)
            return a;
        return (db <= dc) ? b : c;
    endfunction

    function automatic logic [7:0] blend_white(int unsigned v, int unsigned a);
        return 8'((v * a + 255 * (255 - a) + 127) / 255);
    endfunction

    // True when the next plain data byte would read a row-store entry never written
    function automatic bit reads_unwritten();
        int unsigned pos;
        int unsigned row;
        if (in_error)
            return 0;
        pos = (col_byte > row_stride()) ? 0 : col_byte;
        row = (cur_row >= image_rows()) ? 0 : cur_row;
        return pos != 0 && row != 0 && !row_written[pos - 1];
    endfunction

    function automatic void unfilter_byte(in_item_t it);
        int unsigned ch;
        int unsigned stride;
        int unsigned rows;
        int unsigned idx;
        int unsigned left;
        int unsigned above;
        int unsigned diag;
        int unsigned pred;
        int unsigned alpha;
        logic [7:0]  recon;
        logic [7:0]  comp [4];
        out_item_t   px;
        ch     = channels_of(shadow_color);
        stride = row_stride();
        rows   = image_rows();
        if (it.image_start)
        begin
            in_error = 0;
            col_byte = 0;
            cur_row  = 0;
        end
        if (in_error)
            return;
        if (cur_row >= rows)
            cur_row = 0;
        if (col_byte > stride)
            col_byte = 0;

        // Filter byte opens the row
        if (col_byte == 0)
        begin
            recon_hist = '0;
            above_hist = '0;
            if (it.data_byte > MAX_FILTER)
            begin
                in_error = 1;
                px = '0;
                px.bad_filter = 1'b1;
                pending_pixels.push_back(px);
                return;
            end
            cur_filter = filter_t'(it.data_byte[2:0]);
            col_byte   = 1;
            return;
        end

        // Reconstruct one data byte
        idx   = col_byte - 1;
        left  = (recon_hist >> ((ch - 1) * 8)) & 8'hFF;
        diag  = (above_hist >> ((ch - 1) * 8)) & 8'hFF;
        above = (cur_row == 0) ? 0 : above_row[idx];
        if (cur_row == 0)
            diag = 0;
        case (cur_filter)
            FILT_SUB:     pred = left;
            FILT_UP:      pred = above;
            FILT_AVERAGE: pred = (left + above) >> 1;
            FILT_PAETH:   pred = paeth_pick(left, above, diag);
            default:      pred = 0;
        endcase
        recon            = 8'(it.data_byte + pred);
        above_row[idx]   = recon;
        row_written[idx] = 1;
        recon_hist       = {recon_hist[23:0], recon};
        above_hist       = {above_hist[23:0], 8'(above)};

        // Pixel complete: composite onto white
        if ((idx + 1) % ch == 0)
        begin
            for (int k = 0; k < ch; k++)
                comp[k] = 8'(recon_hist >> ((ch - 1 - k) * 8));
            alpha = (ch == 2 || ch == 4) ? comp[ch - 1] : ALPHA_OPAQUE;
            px = '0;
            if (ch <= 2)
            begin
                px.red   = blend_white(comp[0], alpha);
                px.green = px.red;
                px.blue  = px.red;
            end
            else
            begin
                px.red   = blend_white(comp[0], alpha);
                px.green = blend_white(comp[1], alpha);
                px.blue  = blend_white(comp[2], alpha);
            end
            px.last_pixel = (cur_row == rows - 1) && (idx + 1 >= stride);
            pending_pixels.push_back(px);
        end

        col_byte++;
        if (col_byte > stride)
        begin
            col_byte = 0;
            cur_row++;
            if (cur_row >= rows)
                cur_row = 0;
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // One byte transaction; image_start is forced where a plain byte would read
    // a row-store entry that was never written
    task automatic send_byte(int unsigned value, bit start);
        int unsigned gap;
        in_item_t    it;
        it.data_byte   = value[7:0];
        it.image_start = start || reads_unwritten();
        gap = $urandom_range(0, send_gap_max);
        repeat (gap)
        begin
            @(negedge clk);
            byte_valid <= 1'b0;
        end
        @(negedge clk);
        byte_valid <= 1'b1;
        byte_data  <= it;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        if (!(in_error && !it.image_start))
            bytes_taken++;
        unfilter_byte(it);
    endtask

    task automatic send_bytes(bit start, logic [7:0] seq [$]);
        foreach (seq[i])
            send_byte(32'(seq[i]), start && i == 0);
    endtask

    // Stop offering and wait until every expected pixel has come out
    task automatic drain();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t which, int unsigned value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        case (which)
            REG_IMAGE_WIDTH:  shadow_width  = value[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: shadow_height = value[HEIGHT_W-1:0];
            default:          shadow_color  = color_kind_t'(value[1:0]);
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic configure(int unsigned width, int unsigned height, color_kind_t kind);
        drain();
        write_reg(REG_IMAGE_WIDTH, width);
        write_reg(REG_IMAGE_HEIGHT, height);
        write_reg(REG_COLOR_KIND, 32'(kind));
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Every filter type on gray, byte extremes, last pixel of the image
    task automatic test_filters_gray();
        configure(2, 5, COLOR_GRAY);
        send_bytes(1, '{8'(FILT_NONE), 8'h00, 8'hFF});
        send_bytes(0, '{8'(FILT_SUB), 8'h80, 8'h7F});
        send_bytes(0, '{8'(FILT_UP), 8'h01, 8'hFF});
        send_bytes(0, '{8'(FILT_AVERAGE), 8'h33, 8'hCC});
        send_bytes(0, '{8'(FILT_PAETH), 8'h10, 8'hF0});
    endtask

    // Alpha at both extremes, and Paeth on the first and a later row
    task automatic test_alpha_compositing();
        configure(2, 1, COLOR_GRAY_ALPHA);
        send_bytes(1, '{8'(FILT_NONE), 8'hFF, 8'h00, 8'h40, 8'hFF});
        configure(1, 2, COLOR_RGBA);
        send_bytes(1, '{8'(FILT_PAETH), 8'h12, 8'h34, 8'h56, 8'h80});
        send_bytes(0, '{8'(FILT_PAETH), 8'h01, 8'h02, 8'h03, 8'h04});
    endtask

    // Bad filter bytes: first byte, ignored bytes after, on a later row
    task automatic test_bad_filter();
        configure(1, 2, COLOR_GRAY);
        send_bytes(1, '{MAX_FILTER + 8'd1, 8'h00, 8'(FILT_NONE)});
        send_bytes(1, '{8'hFF});
        send_bytes(1, '{8'(FILT_NONE), 8'h07, MAX_FILTER + 8'd1, 8'h09});
    endtask

    // Zero width and height taken as one, image wrap without a start flag,
    // saturated width, full-scale height
    task automatic test_register_extremes();
        configure(0, 0, COLOR_RGBA);
        send_bytes(1, '{8'(FILT_NONE), 8'h01, 8'h02, 8'h03, 8'h04});
        send_bytes(0, '{8'(FILT_SUB), 8'hA5, 8'h5A, 8'hC3, 8'h3C});
        configure((1 << WIDTH_W) - 1, (1 << HEIGHT_W) - 1, COLOR_RGB);
        send_bytes(1, '{8'(FILT_SUB), 8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04});
    endtask

    // Register changes in the middle of a row and of an image
    task automatic test_mid_image_changes();
        configure(1, 3, COLOR_GRAY);
        send_bytes(1, '{8'(FILT_NONE), 8'h10, 8'(FILT_SUB), 8'h20});
        drain();
        write_reg(REG_IMAGE_HEIGHT, 2);
        send_bytes(0, '{8'(FILT_UP), 8'h30});
        configure(4, 1, COLOR_GRAY);
        send_bytes(1, '{8'(FILT_NONE), 8'h01, 8'h02, 8'h03});
        drain();
        write_reg(REG_IMAGE_WIDTH, 2);
        send_bytes(0, '{8'(FILT_AVERAGE), 8'h44, 8'h88});
    endtask

    // Long output hold while bytes keep coming, so the input stalls
    task automatic test_output_backpressure();
        configure(4, 3, COLOR_RGB);
        send_gap_max   = 0;
        hold_request   = 1;
        for (int r = 0; r < 3; r++)
        begin
            send_byte($urandom_range(0, 4), r == 0);
            repeat (12)
                send_byte($urandom_range(0, 255), 0);
        end
        send_gap_max = GAP_MAX;
    endtask

    // Sender stops mid-image until every pixel has drained, then resumes
    task automatic test_sender_pause();
        configure(3, 2, COLOR_GRAY_ALPHA);
        send_byte(32'(FILT_SUB), 1);
        repeat (6)
            send_byte($urandom_range(0, 255), 0);
        drain();
        send_byte(32'(FILT_PAETH), 0);
        repeat (6)
            send_byte($urandom_range(0, 255), 0);
    endtask

    // Mostly well-formed images with random content and settings, plus noise,
    // truncated images and register changes between rows
    task automatic test_random_images();
        int unsigned goal;
        int unsigned width;
        int unsigned height;
        int unsigned rows_sent;
        int unsigned stride;
        int unsigned fbyte;
        bit          cut;
        reg_index_t  which;
        goal = bytes_taken + RANDOM_BYTES;
        while (bytes_taken < goal)
        begin
            send_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            recv_stall_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            if ($urandom_range(0, 9) == 0)
            begin
                // noise burst
                repeat ($urandom_range(3, 12))
                    send_byte($urandom_range(0, 255), $urandom_range(0, 3) == 0);
                continue;
            end
            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 19))
                    0:       width = 0;
                    1:       width = $urandom_range(13, 40);
                    default: width = $urandom_range(1, 6);
                endcase
                case ($urandom_range(0, 19))
                    0:       height = 0;
                    1:       height = (1 << HEIGHT_W) - 1;
                    default: height = $urandom_range(1, 4);
                endcase
                configure(width, height, color_kind_t'($urandom_range(0, 3)));
            end
            rows_sent = (image_rows() < MAX_ROWS_SENT) ? image_rows() : MAX_ROWS_SENT;
            cut = 0;
            for (int r = 0; r < rows_sent && !cut; r++)
            begin
                if (r != 0 && $urandom_range(0, 11) == 0)
                begin
                    drain();
                    which = reg_index_t'($urandom_range(0, 2));
                    case (which)
                        REG_IMAGE_WIDTH:  write_reg(which, $urandom_range(1, 6));
                        REG_IMAGE_HEIGHT: write_reg(which, $urandom_range(1, 4));
                        default:          write_reg(which, $urandom_range(0, 3));
                    endcase
                end
                fbyte = ($urandom_range(0, 39) == 0) ? $urandom_range(5, 255)
                                                     : $urandom_range(0, 4);
                send_byte(fbyte, r == 0 && $urandom_range(0, 7) != 0);
                stride = row_stride();
                for (int b = 0; b < stride && !cut; b++)
                begin
                    if ($urandom_range(0, 63) == 0)
                        cut = 1;
                    else
                        send_byte($urandom_range(0, 255), 0);
                end
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Output side: random stall per transaction, long hold on request
    // ---------------------------------------------------------------
    initial
    begin : receiver
        int unsigned hold;
        pixel_stall = 1'b0;
        forever
        begin
            if (hold_request)
            begin
                hold = HOLD_CYCLES;
                hold_request = 0;
            end
            else
                hold = $urandom_range(0, recv_stall_max);
            repeat (hold)
            begin
                @(negedge clk);
                pixel_stall <= 1'b1;
            end
            @(negedge clk);
            pixel_stall <= 1'b0;
            @(posedge clk);
            while (!pixel_valid)
                @(posedge clk);
        end
    end

    // Compare each output transaction with the oldest expected pixel
    always @(posedge clk)
    begin : check_pixels
        out_item_t want;
        if (rst_n && pixel_valid && !pixel_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected pixel r=%0h g=%0h b=%0h last=%0b bad=%0b",
                             pixel_data.red, pixel_data.green, pixel_data.blue,
                             pixel_data.last_pixel, pixel_data.bad_filter);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel_data.red !== want.red || pixel_data.green !== want.green ||
                    pixel_data.blue !== want.blue ||
                    pixel_data.last_pixel !== want.last_pixel ||
                    pixel_data.bad_filter !== want.bad_filter)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("pixel mismatch: expected r=%0h g=%0h b=%0h last=%0b bad=%0b,",
                                 " got r=%0h g=%0h b=%0h last=%0b bad=%0b",
                                 want.red, want.green, want.blue, want.last_pixel,
                                 want.bad_filter, pixel_data.red, pixel_data.green,
                                 pixel_data.blue, pixel_data.last_pixel,
                                 pixel_data.bad_filter);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction of any kind
    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && !byte_stall) || (pixel_valid && !pixel_stall) || cfg_write)
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        byte_valid     = 1'b0;
        byte_data      = '0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        shadow_width   = 1;
        shadow_height  = 1;
        shadow_color   = COLOR_GRAY;
        recon_hist     = '0;
        above_hist     = '0;
        col_byte       = 0;
        cur_row        = 0;
        cur_filter     = FILT_NONE;
        in_error       = 0;
        mismatches     = 0;
        bytes_taken    = 0;
        idle_count     = 0;
        send_gap_max   = GAP_MAX;
        recv_stall_max = GAP_MAX;
        hold_request   = 0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_filters_gray();
        test_alpha_compositing();
        test_bad_filter();
        test_register_extremes();
        test_mid_image_changes();
        test_output_backpressure();
        test_sender_pause();
        test_random_images();
        drain();

        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: png_unfilter_rgb_composite.f
rtl/pnguf_pkg.sv
rtl/pnguf_ram.sv
rtl/pnguf_front.sv
rtl/pnguf_queue.sv
rtl/pnguf_back.sv
rtl/png_unfilter_rgb_composite.sv
tb/png_unfilter_rgb_composite_tb.sv
